### hw/rtl/sda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sda_pkg - shared types and constants of the stick direction auto-repeat
//
// Holds the operation codes, the register map with its reset values and the
// one-hot sequencer state type.
// ----------------------------------------------------------------------------
package sda_pkg;

    // Operation codes carried in the low bits of s_axis_tuser
    localparam logic [1:0] OP_AXIS  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Register map
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_DZ_RADIUS    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TURN_COS_SQ  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SETTLE_MS    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_REP_MS = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_REP_PERIOD   = 3'd4;

    localparam logic [14:0] DZ_RADIUS_RST    = 15'd14746;
    localparam logic [15:0] TURN_COS_SQ_RST  = 16'd49152;
    localparam logic [15:0] SETTLE_MS_RST    = 16'd16;
    localparam logic [15:0] FIRST_REP_MS_RST = 16'd320;
    localparam logic [15:0] REP_PERIOD_RST   = 16'd110;

    // Fixed field widths
    localparam int unsigned ID_W   = 8;
    localparam int unsigned MS_W   = 16;
    localparam int unsigned COS_W  = 16;
    localparam int unsigned USER_W = 3;

    // Sequencer states, one-hot
    typedef enum logic [16:0] {
        ST_IDLE  = 17'h00001,
        ST_PX    = 17'h00002,
        ST_PY    = 17'h00004,
        ST_DZ    = 17'h00008,
        ST_DZCHK = 17'h00010,
        ST_DOTY  = 17'h00020,
        ST_DOTC  = 17'h00040,
        ST_ADSQ  = 17'h00080,
        ST_DIRX  = 17'h00100,
        ST_DIRY  = 17'h00200,
        ST_MDSUM = 17'h00400,
        ST_XMUL  = 17'h00800,
        ST_RLO   = 17'h01000,
        ST_RHI   = 17'h02000,
        ST_RACC  = 17'h04000,
        ST_CMP   = 17'h08000,
        ST_DONE  = 17'h10000
    } sda_state_t;

endpackage
`default_nettype wire

### hw/rtl/stick_direction_autorepeat.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stick_direction_autorepeat - analog stick auto-repeat with dead zone
//
// Turns stick axis updates and millisecond ticks into select-request pulses,
// with a settle delay after activation or a sharp turn, then a first repeat
// and a steady repeat period.
//
//  Channel   Dir  Handshake                  Content
//  s_axis    in   s_axis_tvalid/tready       operation, axis select (tuser),
//                                            stick id, axis value, ms (tdata)
//  m_axis    out  m_axis_tvalid/tready       request, active, direction
//  cfg       in   cfg_valid/cfg_ready        register index, write data
//
//  Sequencing: a tick, clear or unused item goes from idle straight to the
//  done state; an axis item ends after the dead zone test (inside the dead
//  zone or on activation), after the sign of the dot product (turn found
//  there) or after the full angle test. The one shared multiplier is
//  registered and is stepped through every square and product of both tests.
//  Reset: aresetn low clears all stick state and loads register defaults.
//  Stalls: a result held on m_axis keeps the block from finishing the next
//  item, and no new item is taken until the sequencer is back in idle.
// ----------------------------------------------------------------------------
module stick_direction_autorepeat #(
    parameter int unsigned AXIS_BITS = 16,
    parameter int unsigned TIME_BITS = 20
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // s_axis_tdata: stick_id, axis_value, ms_passed (lowest bit up), zero pad
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [((24+AXIS_BITS+7)/8)*8-1:0]   s_axis_tdata,
    // s_axis_tuser: operation, axis_select (lowest bit up)
    input  wire  [sda_pkg::USER_W-1:0]          s_axis_tuser,
    // m_axis_tdata: select_request, nav_active, dir_x_out, dir_y_out, zero pad
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [((2+2*AXIS_BITS+7)/8)*8-1:0]  m_axis_tdata,
    // configuration write channel
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [sda_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire  [sda_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import sda_pkg::*;

    localparam int unsigned A        = AXIS_BITS;
    localparam int unsigned MAG_W    = 2 * A;          // squared magnitudes
    localparam int unsigned DOT_W    = 2 * A + 1;      // signed dot product
    localparam int unsigned MUL_W    = 2 * A;          // multiplier operand
    localparam int unsigned PROD_W   = 2 * MUL_W;      // multiplier result
    localparam int unsigned WIDE_W   = 4 * A + COS_W;  // angle test sides
    localparam int unsigned M_DATA_W = ((2 + 2 * A + 7) / 8) * 8;
    localparam int unsigned DZ_SHL   = (A >= 16) ? A - 16 : 0;
    localparam int unsigned DZ_SHR   = (A < 16) ? 16 - A : 0;

    // Magnitude of a signed axis value; the most negative value maps to 2^(A-1)
    function automatic logic [A-1:0] mag(input logic [A-1:0] v);
        mag = v[A-1] ? (~v + 1'b1) : v;
    endfunction

    // ------------------------------------------------------------------
    // Input item fields
    // ------------------------------------------------------------------
    logic [1:0]      in_op;
    logic            in_sel;
    logic [ID_W-1:0] in_id;
    logic [A-1:0]    in_axis;
    logic [MS_W-1:0] in_ms;

    assign in_op   = s_axis_tuser[1:0];
    assign in_sel  = s_axis_tuser[2];
    assign in_id   = s_axis_tdata[ID_W-1:0];
    assign in_axis = s_axis_tdata[ID_W +: A];
    assign in_ms   = s_axis_tdata[ID_W + A +: MS_W];

    // ------------------------------------------------------------------
    // Configuration registers; writes are always taken
    // ------------------------------------------------------------------
    logic [14:0]      dz_radius_reg;
    logic [COS_W-1:0] turn_cos_sq_reg;
    logic [MS_W-1:0]  settle_ms_reg;
    logic [MS_W-1:0]  first_rep_ms_reg;
    logic [MS_W-1:0]  rep_period_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dz_radius_reg    <= DZ_RADIUS_RST;
            turn_cos_sq_reg  <= TURN_COS_SQ_RST;
            settle_ms_reg    <= SETTLE_MS_RST;
            first_rep_ms_reg <= FIRST_REP_MS_RST;
            rep_period_reg   <= REP_PERIOD_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                REG_DZ_RADIUS:    dz_radius_reg    <= cfg_data[14:0];
                REG_TURN_COS_SQ:  turn_cos_sq_reg  <= cfg_data;
                REG_SETTLE_MS:    settle_ms_reg    <= cfg_data;
                REG_FIRST_REP_MS: first_rep_ms_reg <= cfg_data;
                REG_REP_PERIOD:   rep_period_reg   <= cfg_data;
                default: ;  // drop writes beyond the register map
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stick state, sequencer and work registers
    // ------------------------------------------------------------------
    sda_state_t state_reg, state_next;

    logic                 owner_valid_reg, owner_valid_next;
    logic [ID_W-1:0]      owner_id_reg, owner_id_next;
    logic [A-1:0]         pos_x_reg, pos_x_next;
    logic [A-1:0]         pos_y_reg, pos_y_next;
    logic [A-1:0]         dir_x_reg, dir_x_next;
    logic [A-1:0]         dir_y_reg, dir_y_next;
    logic                 engaged_reg, engaged_next;
    logic                 pending_reg, pending_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic                 req_reg, req_next;

    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [MAG_W-1:0]     mp_reg, mp_next;      // |pos|^2
    logic [DOT_W-1:0]     dot_reg, dot_next;    // dot(dir, pos)
    logic [MAG_W-1:0]     md_reg, md_next;      // |dir|^2
    logic [COS_W-1:0]     xh_reg, xh_next;      // upper part of |dir|^2 * cos^2
    logic [WIDE_W-1:0]    lhs_reg, lhs_next;    // dot^2 * 2^16
    logic [WIDE_W-1:0]    rhs_reg, rhs_next;    // cos^2 * |dir|^2 * |pos|^2

    logic                 m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]  m_data_reg, m_data_next;

    // ------------------------------------------------------------------
    // Shared multiplier: operands picked by state, product registered
    // ------------------------------------------------------------------
    logic [MUL_W-1:0] mul_a, mul_b;
    logic [MUL_W-1:0] dz_op;

    assign dz_op = (MUL_W'(dz_radius_reg) << DZ_SHL) >> DZ_SHR;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_PX: begin
                mul_a = MUL_W'(mag(pos_x_reg));
                mul_b = MUL_W'(mag(pos_x_reg));
            end
            ST_PY: begin
                mul_a = MUL_W'(mag(pos_y_reg));
                mul_b = MUL_W'(mag(pos_y_reg));
            end
            ST_DZ: begin
                mul_a = dz_op;
                mul_b = dz_op;
            end
            ST_DZCHK: begin
                mul_a = MUL_W'(mag(dir_x_reg));
                mul_b = MUL_W'(mag(pos_x_reg));
            end
            ST_DOTY: begin
                mul_a = MUL_W'(mag(dir_y_reg));
                mul_b = MUL_W'(mag(pos_y_reg));
            end
            ST_ADSQ: begin
                mul_a = dot_reg[MUL_W-1:0];
                mul_b = dot_reg[MUL_W-1:0];
            end
            ST_DIRX: begin
                mul_a = MUL_W'(mag(dir_x_reg));
                mul_b = MUL_W'(mag(dir_x_reg));
            end
            ST_DIRY: begin
                mul_a = MUL_W'(mag(dir_y_reg));
                mul_b = MUL_W'(mag(dir_y_reg));
            end
            ST_XMUL: begin
                mul_a = md_reg;
                mul_b = MUL_W'(turn_cos_sq_reg);
            end
            ST_RLO: begin
                mul_a = prod_reg[MUL_W-1:0];
                mul_b = mp_reg;
            end
            ST_RHI: begin
                mul_a = MUL_W'(xh_reg);
                mul_b = mp_reg;
            end
            default: ;
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // ------------------------------------------------------------------
    // Signed dot product terms: the product register holds a magnitude,
    // the sign comes from the operands, which stay put during the sequence
    // ------------------------------------------------------------------
    logic [DOT_W-1:0] term;
    logic [DOT_W-1:0] term_x, term_y;
    logic [DOT_W-1:0] dot_sum;
    logic             dot_nonpos;

    assign term    = DOT_W'(prod_reg[MAG_W-1:0]);
    assign term_x  = (dir_x_reg[A-1] ^ pos_x_reg[A-1]) ? (~term + 1'b1) : term;
    assign term_y  = (dir_y_reg[A-1] ^ pos_y_reg[A-1]) ? (~term + 1'b1) : term;
    assign dot_sum = dot_reg + term_y;
    assign dot_nonpos = dot_sum[DOT_W-1] || (dot_sum == '0);

    // ------------------------------------------------------------------
    // Tick arithmetic: saturating elapsed time and repeat reload
    // ------------------------------------------------------------------
    logic [TIME_BITS:0]   tick_sum;
    logic [TIME_BITS-1:0] tick_sat;
    logic [MS_W-1:0]      reload;

    assign tick_sum = {1'b0, elapsed_reg} + (TIME_BITS + 1)'(in_ms);
    assign tick_sat = tick_sum[TIME_BITS] ? '1 : tick_sum[TIME_BITS-1:0];
    assign reload   = (first_rep_ms_reg > rep_period_reg) ?
                      (first_rep_ms_reg - rep_period_reg) : '0;

    logic other_stick;
    assign other_stick = owner_valid_reg && (owner_id_reg != in_id);

    assign s_axis_tready = (state_reg == ST_IDLE);

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        state_next       = state_reg;
        owner_valid_next = owner_valid_reg;
        owner_id_next    = owner_id_reg;
        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        dir_x_next       = dir_x_reg;
        dir_y_next       = dir_y_reg;
        engaged_next     = engaged_reg;
        pending_next     = pending_reg;
        elapsed_next     = elapsed_reg;
        req_next         = req_reg;
        mp_next          = mp_reg;
        dot_next         = dot_reg;
        md_next          = md_reg;
        xh_next          = xh_reg;
        lhs_next         = lhs_reg;
        rhs_next         = rhs_reg;
        m_valid_next     = m_valid_reg && !m_axis_tready;
        m_data_next      = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    req_next   = 1'b0;
                    state_next = ST_DONE;
                    case (in_op)
                        OP_AXIS: begin
                            // a different stick takes over: start from clean state
                            if (other_stick) begin
                                pos_x_next   = '0;
                                pos_y_next   = '0;
                                dir_x_next   = '0;
                                dir_y_next   = '0;
                                engaged_next = 1'b0;
                                pending_next = 1'b0;
                                elapsed_next = '0;
                            end
                            owner_valid_next = 1'b1;
                            owner_id_next    = in_id;
                            if (in_sel) begin
                                pos_y_next = in_axis;
                            end else begin
                                pos_x_next = in_axis;
                            end
                            state_next = ST_PX;
                        end
                        OP_TICK: begin
                            if (engaged_reg) begin
                                if (pending_reg) begin
                                    if (tick_sat < TIME_BITS'(settle_ms_reg)) begin
                                        elapsed_next = tick_sat;
                                    end else begin
                                        pending_next = 1'b0;
                                        elapsed_next = '0;
                                        req_next     = 1'b1;
                                    end
                                end else if (tick_sat < TIME_BITS'(first_rep_ms_reg)) begin
                                    elapsed_next = tick_sat;
                                end else begin
                                    elapsed_next = TIME_BITS'(reload);
                                    req_next     = 1'b1;
                                end
                            end
                        end
                        OP_CLEAR: begin
                            owner_valid_next = 1'b0;
                            owner_id_next    = '0;
                            pos_x_next       = '0;
                            pos_y_next       = '0;
                            dir_x_next       = '0;
                            dir_y_next       = '0;
                            engaged_next     = 1'b0;
                            pending_next     = 1'b0;
                            elapsed_next     = '0;
                        end
                        default: ;  // unused code: report status only
                    endcase
                end
            end
            ST_PX:   state_next = ST_PY;
            ST_PY: begin
                mp_next    = prod_reg[MAG_W-1:0];
                state_next = ST_DZ;
            end
            ST_DZ: begin
                mp_next    = mp_reg + prod_reg[MAG_W-1:0];
                state_next = ST_DZCHK;
            end
            ST_DZCHK: begin
                // product register holds the squared dead zone radius
                if (mp_reg < prod_reg[MAG_W-1:0]) begin
                    engaged_next = 1'b0;
                    pending_next = 1'b0;
                    elapsed_next = '0;
                    state_next   = ST_DONE;
                end else if (!engaged_reg) begin
                    engaged_next = 1'b1;
                    pending_next = 1'b1;
                    elapsed_next = '0;
                    dir_x_next   = pos_x_reg;
                    dir_y_next   = pos_y_reg;
                    state_next   = ST_DONE;
                end else begin
                    state_next = ST_DOTY;
                end
            end
            ST_DOTY: begin
                dot_next   = term_x;
                state_next = ST_DOTC;
            end
            ST_DOTC: begin
                dot_next = dot_sum;
                if (dot_nonpos) begin
                    // facing away or across: always a turn
                    pending_next = 1'b1;
                    elapsed_next = '0;
                    dir_x_next   = pos_x_reg;
                    dir_y_next   = pos_y_reg;
                    state_next   = ST_DONE;
                end else begin
                    state_next = ST_ADSQ;
                end
            end
            ST_ADSQ: state_next = ST_DIRX;
            ST_DIRX: begin
                lhs_next   = {prod_reg, {COS_W{1'b0}}};
                state_next = ST_DIRY;
            end
            ST_DIRY: begin
                md_next    = prod_reg[MAG_W-1:0];
                state_next = ST_MDSUM;
            end
            ST_MDSUM: begin
                md_next    = md_reg + prod_reg[MAG_W-1:0];
                state_next = ST_XMUL;
            end
            ST_XMUL: state_next = ST_RLO;
            ST_RLO: begin
                xh_next    = prod_reg[MAG_W +: COS_W];
                state_next = ST_RHI;
            end
            ST_RHI: begin
                rhs_next   = WIDE_W'(prod_reg);
                state_next = ST_RACC;
            end
            ST_RACC: begin
                rhs_next   = rhs_reg + (WIDE_W'(prod_reg) << MAG_W);
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (lhs_reg < rhs_reg) begin
                    pending_next = 1'b1;
                    elapsed_next = '0;
                end
                dir_x_next = pos_x_reg;
                dir_y_next = pos_y_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // load the output register once the previous transfer has gone
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next            = 1'b1;
                    m_data_next             = '0;
                    m_data_next[0]          = req_reg;
                    m_data_next[1]          = engaged_reg;
                    m_data_next[2 +: A]     = dir_x_reg;
                    m_data_next[2 + A +: A] = dir_y_reg;
                    state_next              = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            owner_valid_reg <= 1'b0;
            owner_id_reg    <= '0;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            dir_x_reg       <= '0;
            dir_y_reg       <= '0;
            engaged_reg     <= 1'b0;
            pending_reg     <= 1'b0;
            elapsed_reg     <= '0;
            req_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            owner_valid_reg <= owner_valid_next;
            owner_id_reg    <= owner_id_next;
            pos_x_reg       <= pos_x_next;
            pos_y_reg       <= pos_y_next;
            dir_x_reg       <= dir_x_next;
            dir_y_reg       <= dir_y_next;
            engaged_reg     <= engaged_next;
            pending_reg     <= pending_next;
            elapsed_reg     <= elapsed_next;
            req_reg         <= req_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // work registers and payload: no reset needed
    always_ff @(posedge aclk) begin
        prod_reg   <= prod_next;
        mp_reg     <= mp_next;
        dot_reg    <= dot_next;
        md_reg     <= md_next;
        xh_reg     <= xh_next;
        lhs_reg    <= lhs_next;
        rhs_reg    <= rhs_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_req_needs_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[0]) |-> m_axis_tdata[1])
        else $error("select request shown while stick is idle");

    a_pending_needs_engaged: assert property (@(posedge aclk) disable iff (!aresetn)
        !engaged_reg |-> !pending_reg)
        else $error("settle pending while not engaged");

    a_idle_time_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !engaged_reg |-> (elapsed_reg == '0))
        else $error("elapsed time running while not engaged");

    a_no_owner_no_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        !owner_valid_reg |-> ((pos_x_reg == '0) && (pos_y_reg == '0)))
        else $error("position held without an owning stick");

endmodule
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the stick direction auto-repeat
//
// Streams axis updates, millisecond ticks, clears and unused codes into the
// block under random valid and ready gaps, and predicts every status word from
// a scoreboard that tracks owner, position, latched direction, settle state
// and elapsed time. Register settings change between phases while the block
// is idle, and cover the extremes of every register.
// ----------------------------------------------------------------------------
module tb;
    import sda_pkg::*;

    localparam int unsigned IN_W         = 40;
    localparam int unsigned OUT_W        = 40;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned PHASE_ITEMS  = 235;
    localparam int unsigned PHASES       = 8;

    typedef struct packed {
        logic               req;
        logic               active;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
    } stick_status_t;

    // Scoreboard: predicts the status word of every accepted item and checks
    // the result transfers against them in order.
    class stick_scoreboard;
        stick_status_t      awaited[$];
        int unsigned        failures;
        int unsigned        checked;
        int unsigned        requests;
        logic [14:0]        dz_radius;
        logic [15:0]        cos_sq;
        logic [15:0]        settle_ms;
        logic [15:0]        first_rep_ms;
        logic [15:0]        rep_period;
        bit                 owner_valid;
        logic [7:0]         owner_id;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        bit                 engaged;
        bit                 settling;
        logic [19:0]        elapsed_ms;

        function new();
            dz_radius    = DZ_RADIUS_RST;
            cos_sq       = TURN_COS_SQ_RST;
            settle_ms    = SETTLE_MS_RST;
            first_rep_ms = FIRST_REP_MS_RST;
            rep_period   = REP_PERIOD_RST;
            failures     = 0;
            checked      = 0;
            requests     = 0;
            clear_stick();
        endfunction

        function void clear_stick();
            owner_valid = 1'b0;
            owner_id    = '0;
            pos_x       = '0;
            pos_y       = '0;
            dir_x       = '0;
            dir_y       = '0;
            engaged     = 1'b0;
            settling    = 1'b0;
            elapsed_ms  = '0;
        endfunction

        function logic [63:0] mag_sq(logic signed [15:0] a, logic signed [15:0] b);
            longint la;
            longint lb;
            la = a;
            lb = b;
            return la * la + lb * lb;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [15:0] value);
            case (idx)
                REG_DZ_RADIUS:    dz_radius    = value[14:0];
                REG_TURN_COS_SQ:  cos_sq       = value;
                REG_SETTLE_MS:    settle_ms    = value;
                REG_FIRST_REP_MS: first_rep_ms = value;
                REG_REP_PERIOD:   rep_period   = value;
                default: ;
            endcase
        endfunction

        function void note_item(logic [1:0] op, logic [7:0] id, logic sel,
                                logic signed [15:0] value, logic [15:0] ms);
            stick_status_t res;
            longint        dot;
            logic [127:0]  lhs;
            logic [127:0]  rhs;
            logic [20:0]   sum;
            bit            turn;
            res.req = 1'b0;
            case (op)
                OP_AXIS: begin
                    // a different stick takes over from a clean slate
                    if (owner_valid && owner_id != id) begin
                        clear_stick();
                    end
                    owner_valid = 1'b1;
                    owner_id    = id;
                    if (sel) begin
                        pos_y = value;
                    end else begin
                        pos_x = value;
                    end
                    if (mag_sq(pos_x, pos_y) < 64'(dz_radius) * 64'(dz_radius)) begin
                        engaged    = 1'b0;
                        settling   = 1'b0;
                        elapsed_ms = '0;
                    end else begin
                        // turn: dot <= 0, or dot^2 below cos^2 * |a|^2 * |b|^2
                        dot = longint'(dir_x) * longint'(pos_x)
                            + longint'(dir_y) * longint'(pos_y);
                        if (dot <= 0) begin
                            turn = 1'b1;
                        end else begin
                            lhs  = (128'(dot) * 128'(dot)) << 16;
                            rhs  = 128'(mag_sq(dir_x, dir_y)) * 128'(cos_sq)
                                 * 128'(mag_sq(pos_x, pos_y));
                            turn = lhs < rhs;
                        end
                        if (!engaged || turn) begin
                            settling   = 1'b1;
                            elapsed_ms = '0;
                        end
                        engaged = 1'b1;
                        dir_x   = pos_x;
                        dir_y   = pos_y;
                    end
                end
                OP_TICK: begin
                    if (engaged) begin
                        sum        = {1'b0, elapsed_ms} + 21'(ms);
                        elapsed_ms = sum[20] ? 20'hFFFFF : sum[19:0];
                        if (settling) begin
                            if (elapsed_ms >= 20'(settle_ms)) begin
                                settling   = 1'b0;
                                elapsed_ms = '0;
                                res.req    = 1'b1;
                            end
                        end else if (elapsed_ms >= 20'(first_rep_ms)) begin
                            // period longer than first repeat floors at zero
                            elapsed_ms = (first_rep_ms > rep_period) ?
                                         20'(first_rep_ms - rep_period) : '0;
                            res.req    = 1'b1;
                        end
                    end
                end
                OP_CLEAR: clear_stick();
                default: ;
            endcase
            res.active = engaged;
            res.dir_x  = dir_x;
            res.dir_y  = dir_y;
            awaited.push_back(res);
        endfunction

        task report(string msg);
            $display("error at result %0d: %s", checked, msg);
            failures++;
        endtask

        task check_result(logic [OUT_W-1:0] word);
            stick_status_t got;
            stick_status_t want;
            got.req    = word[0];
            got.active = word[1];
            got.dir_x  = word[17:2];
            got.dir_y  = word[33:18];
            checked++;
            if (awaited.size() == 0) begin
                report("result transfer with no item awaiting it");
                return;
            end
            want = awaited.pop_front();
            if (got.req) begin
                requests++;
            end
            if (got.req !== want.req) begin
                report($sformatf("select_request %0b, predicted %0b", got.req, want.req));
            end
            if (got.active !== want.active) begin
                report($sformatf("nav_active %0b, predicted %0b", got.active, want.active));
            end
            if (got.dir_x !== want.dir_x) begin
                report($sformatf("dir_x %0d, predicted %0d", got.dir_x, want.dir_x));
            end
            if (got.dir_y !== want.dir_y) begin
                report($sformatf("dir_y %0d, predicted %0d", got.dir_y, want.dir_y));
            end
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata;
    logic [USER_W-1:0]     s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    stick_scoreboard sb;
    int unsigned     items_sent    = 0;
    int unsigned     settings_used = 1;
    int unsigned     quiet_cycles  = 0;
    int unsigned     cur_dz;
    bit              quiet_in      = 1'b0;
    bit              quiet_out     = 1'b0;
    logic [7:0]      stick;
    int              last_x;
    int              last_y;

    stick_direction_autorepeat uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Sample both channels at the rising edge; the check runs first, since a
    // result on this edge always belongs to an earlier item.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_item(s_axis_tuser[1:0], s_axis_tdata[7:0], s_axis_tuser[2],
                             s_axis_tdata[23:8], s_axis_tdata[39:24]);
            end
        end
    end

    // Watchdog: any transfer on any channel restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("stick_direction_autorepeat: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: a randomly drawn stall before each transfer, with stall-free stretches.
    initial begin
        int unsigned stall;
        m_axis_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                quiet_out = !quiet_out;
            end
            stall = quiet_out ? 0 : $urandom_range(0, 5);
            repeat (stall) begin
                @(negedge aclk);
                m_axis_tready <= 1'b0;
            end
            @(negedge aclk);
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Offer one item after a random gap and hold it until the transfer.
    // Valid stays high into the next item when no gap is drawn.
    task push_item(input logic [1:0] op, input logic [7:0] id, input logic sel,
                   input logic [15:0] value, input logic [15:0] ms);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0) begin
            quiet_in = !quiet_in;
        end
        gap = quiet_in ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ms, value, id};
        s_axis_tuser  <= {sel, op};
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
        items_sent++;
    endtask

    // Unused fields of each item carry random bits.
    task send_axis(input logic [7:0] id, input logic sel, input logic [15:0] value);
        push_item(OP_AXIS, id, sel, value, 16'($urandom));
    endtask

    task send_tick(input logic [15:0] ms);
        push_item(OP_TICK, 8'($urandom), 1'($urandom), 16'($urandom), ms);
    endtask

    task send_plain(input logic [1:0] op);
        push_item(op, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        sb.write_reg(idx, value);
        if (idx == REG_DZ_RADIUS) begin
            cur_dz = 32'(value[14:0]);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task load_settings(input logic [15:0] dz, input logic [15:0] cos_sq,
                       input logic [15:0] settle, input logic [15:0] first_rep,
                       input logic [15:0] rep);
        write_reg(REG_DZ_RADIUS, dz);
        write_reg(REG_TURN_COS_SQ, cos_sq);
        write_reg(REG_SETTLE_MS, settle);
        write_reg(REG_FIRST_REP_MS, first_rep);
        write_reg(REG_REP_PERIOD, rep);
        settings_used++;
    endtask

    // Drop valid, wait for every predicted status, then let the sequencer run out.
    task drain();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.awaited.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Mostly one stick moving and ticking; some takeovers, clears and noise.
    task run_random(input int unsigned n);
        int unsigned r;
        int unsigned k;
        int          v;
        logic        sel;
        logic [15:0] ms;
        last_x = 0;
        last_y = 0;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 44 || (r >= 88 && r < 92)) begin
                if (r >= 88) begin
                    // takeover by another stick clears the position
                    stick  = 8'($urandom);
                    last_x = 0;
                    last_y = 0;
                end
                sel = 1'($urandom_range(0, 1));
                v   = sel ? last_y : last_x;
                k   = $urandom_range(0, 9);
                case (k)
                    0: begin
                        if ($urandom_range(0, 2) == 0) begin
                            v = 0;
                        end else begin
                            v = $urandom_range(0, 1) ? 32767 : -32768;
                        end
                    end
                    1, 2, 3: v = v + int'($urandom_range(0, 6000)) - 3000;
                    4, 5: begin
                        v = int'(cur_dz) + int'($urandom_range(0, 600)) - 300;
                        if ($urandom_range(0, 1)) begin
                            v = -v;
                        end
                    end
                    default: v = int'($urandom_range(0, 65535)) - 32768;
                endcase
                if (v > 32767) begin
                    v = 32767;
                end
                if (v < -32768) begin
                    v = -32768;
                end
                if (sel) begin
                    last_y = v;
                end else begin
                    last_x = v;
                end
                send_axis(stick, sel, v[15:0]);
            end else if (r < 88) begin
                k = $urandom_range(0, 9);
                case (k)
                    0, 1, 2, 3, 4: ms = 16'($urandom_range(0, 400));
                    5, 6:          ms = 16'($urandom);
                    7:             ms = 16'h0000;
                    8:             ms = 16'hFFFF;
                    default:       ms = 16'($urandom_range(0, 40));
                endcase
                send_tick(ms);
            end else if (r < 96) begin
                last_x = 0;
                last_y = 0;
                send_plain(OP_CLEAR);
            end else if (r < 98) begin
                send_plain(OP_UNUSED);
            end else begin
                send_tick(16'($urandom_range(0, 20)));
            end
        end
    endtask

    initial begin
        int unsigned phase;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_addr      = '0;
        cfg_data      = '0;
        sb            = new();
        cur_dz        = 32'(DZ_RADIUS_RST);
        stick         = 8'h00;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed pass on reset settings
        send_tick(16'd100);                 // tick with no owner
        send_axis(8'h00, 1'b0, 16'h7FFF);   // full right: activate and settle
        send_tick(16'd15);
        send_tick(16'd1);                   // settle reached: first request
        send_tick(16'd319);
        send_tick(16'd1);                   // first repeat
        send_tick(16'd110);                 // steady repeat
        send_axis(8'h00, 1'b1, 16'd8000);   // shallow turn, full angle test
        send_axis(8'h00, 1'b0, 16'h8000);   // reversal: negative dot product
        send_tick(16'd16);
        send_axis(8'hFF, 1'b1, 16'h7FFF);   // other stick takes over
        send_axis(8'hFF, 1'b0, 16'h0000);
        send_axis(8'hFF, 1'b1, 16'h0000);   // back to the centre
        send_tick(16'hFFFF);                // tick while idle
        send_axis(8'hFF, 1'b1, 16'h8000);
        send_plain(OP_UNUSED);
        send_plain(OP_CLEAR);
        send_axis(8'h3C, 1'b0, 16'd14746);  // exactly on the dead zone edge
        send_axis(8'h3C, 1'b0, 16'd14745);  // just inside
        send_tick(16'hFFFF);
        send_axis(8'h3C, 1'b0, 16'hC666);   // left, on the edge
        send_tick(16'hFFFF);
        send_tick(16'hFFFF);
        stick = 8'h3C;
        run_random(PHASE_ITEMS);

        for (phase = 1; phase < PHASES; phase++) begin
            drain();
            case (phase)
                1: load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                2: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: load_settings(16'd1000, 16'hFFFF, 16'd5, 16'd40, 16'd200);
                4: load_settings(16'(DZ_RADIUS_RST), TURN_COS_SQ_RST, SETTLE_MS_RST,
                                 FIRST_REP_MS_RST, REP_PERIOD_RST);
                default: load_settings(16'($urandom), 16'($urandom),
                                       16'($urandom_range(0, 100)),
                                       16'($urandom_range(0, 600)),
                                       16'($urandom_range(0, 600)));
            endcase
            if (phase == 1) begin
                // zero dead zone: a zero vector is active, zero direction turns
                send_plain(OP_CLEAR);
                send_axis(stick, 1'b0, 16'h0000);
                send_axis(stick, 1'b1, 16'h0000);
                send_tick(16'h0000);
            end
            run_random(PHASE_ITEMS);
        end

        drain();
        $display("%0d items over %0d register settings, %0d results checked",
                 items_sent, settings_used, sb.checked);
        $display("%0d select requests seen, %0d field errors", sb.requests, sb.failures);
        if (sb.failures == 0) begin
            $display("stick_direction_autorepeat: match");
        end else begin
            $display("stick_direction_autorepeat: mismatch");
        end
        $finish;
    end

endmodule
